[rtl/lfutb_pkg.sv]
// shared types and codes for the lfu/lru handle table
`default_nettype none
package lfutb_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_INSERT
  } upd_op_t;

  localparam logic       CMD_LOOKUP   = 1'b0;
  localparam logic       CMD_INSERT   = 1'b1;

  localparam logic [1:0] STAT_HIT     = 2'd0;
  localparam logic [1:0] STAT_MISS    = 2'd1;
  localparam logic [1:0] STAT_NEW     = 2'd2;
  localparam logic [1:0] STAT_REFRESH = 2'd3;

  localparam int         HANDLE_BITS  = 31;
  localparam int         SIZE_BITS    = 48;
  localparam int         TAG_BITS     = 32;
  localparam int         CAP_BITS     = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage
`default_nettype wire

[rtl/lfutb_cell.sv]
// one table slot: stored entry, its piece of the search wave and its update rule
`default_nettype none
module lfutb_cell import lfutb_pkg::*; #(
  parameter int ID         = 0,
  parameter int IDX_BITS   = 4,
  parameter int FILL_BITS  = 5,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // search wave from the previous slot
  input  wire logic [KEY_BITS-1:0]    req_key,
  input  wire logic                   hit_i,
  input  wire logic [IDX_BITS-1:0]    hit_idx_i,
  input  wire logic                   free_i,
  input  wire logic [IDX_BITS-1:0]    free_idx_i,
  input  wire logic [FILL_BITS-1:0]   fill_i,
  input  wire logic                   vic_i,
  input  wire logic [IDX_BITS-1:0]    vic_idx_i,
  input  wire logic [COUNT_BITS-1:0]  vic_cnt_i,
  input  wire logic [IDX_BITS-1:0]    vic_rank_i,
  // search wave to the next slot
  output logic                        hit_o,
  output logic [IDX_BITS-1:0]         hit_idx_o,
  output logic                        free_o,
  output logic [IDX_BITS-1:0]         free_idx_o,
  output logic [FILL_BITS-1:0]        fill_o,
  output logic                        vic_o,
  output logic [IDX_BITS-1:0]         vic_idx_o,
  output logic [COUNT_BITS-1:0]       vic_cnt_o,
  output logic [IDX_BITS-1:0]         vic_rank_o,
  // broadcast update
  input  wire logic                   upd_en,
  input  wire upd_op_t                upd_op,
  input  wire logic [IDX_BITS-1:0]    tgt_idx,
  input  wire logic [IDX_BITS-1:0]    tgt_rank,
  input  wire logic                   wr_data,
  input  wire logic                   do_evict,
  input  wire logic [IDX_BITS-1:0]    evict_idx,
  input  wire logic [IDX_BITS-1:0]    evict_rank,
  input  wire logic [HANDLE_BITS-1:0] wr_handle,
  input  wire logic [SIZE_BITS-1:0]   wr_size,
  // stored contents
  output logic [KEY_BITS-1:0]         key,
  output logic [HANDLE_BITS-1:0]      handle,
  output logic [SIZE_BITS-1:0]        size,
  output logic [IDX_BITS-1:0]         rank
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(ID);

  logic                  valid;
  logic [COUNT_BITS-1:0] cnt;
  logic                  take_hit;
  logic                  take_free;
  logic                  take_vic;
  logic [IDX_BITS-1:0]   rank_aged;

  assign take_hit  = !hit_i && valid && (key == req_key);
  assign take_free = !free_i && !valid;
  assign take_vic  = valid && (!vic_i || (cnt < vic_cnt_i) ||
                               ((cnt == vic_cnt_i) && (rank > vic_rank_i)));
  // close the gap left by the victim, then age behind the new entry
  assign rank_aged = rank - IDX_BITS'(do_evict && (rank > evict_rank)) + 1'b1;

  always_ff @(posedge clk) begin
    hit_o      <= hit_i | take_hit;
    hit_idx_o  <= take_hit ? MY_IDX : hit_idx_i;
    free_o     <= free_i | take_free;
    free_idx_o <= take_free ? MY_IDX : free_idx_i;
    fill_o     <= fill_i + FILL_BITS'(valid);
    vic_o      <= vic_i | take_vic;
    vic_idx_o  <= take_vic ? MY_IDX : vic_idx_i;
    vic_cnt_o  <= take_vic ? cnt : vic_cnt_i;
    vic_rank_o <= take_vic ? rank : vic_rank_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd_en) begin
      case (upd_op)
        OP_TOUCH: begin
          if (tgt_idx == MY_IDX) begin
            if (cnt != '1) cnt <= cnt + 1'b1;
            rank <= '0;
            if (wr_data) begin
              handle <= wr_handle;
              size   <= wr_size;
            end
          end else if (valid && (rank < tgt_rank)) begin
            rank <= rank + 1'b1;
          end
        end
        OP_INSERT: begin
          if (tgt_idx == MY_IDX) begin
            valid  <= 1'b1;
            key    <= req_key;
            handle <= wr_handle;
            size   <= wr_size;
            cnt    <= COUNT_BITS'(1);
            rank   <= '0;
          end else if (do_evict && (evict_idx == MY_IDX)) begin
            valid <= 1'b0;
          end else if (valid) begin
            rank <= rank_aged;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/lfu_lru_tiebreak_cache_table_unit.sv]
// Fully associative handle table, least-used eviction with least-recent tie-break.
// Requests come in on in_valid/in_ready with cmd, key_tag, handle_in, size_in;
// cmd 0 looks a key up, cmd 1 inserts it. One result per request leaves on
// out_valid/out_ready with status, handle_out, size_out and, for an insert that
// pushed an entry out, evicted/evicted_handle/evicted_key.
// The slots form a chain; a search wave (hit, first free slot, fill, victim)
// moves one slot per cycle through the scan state; once it has left the last
// slot, the apply state updates the table and registers the result. The scan
// length of the slot chain sets the throughput: no new request is taken before
// the last one's update, and in_ready is high only while no request is in work.
// The result sits in an output register; the next request is accepted while it
// waits, but its update holds until the receiver has taken the earlier result.
// cfg_we writes capacity from cfg_data (0 acts as 1, values above ENTRIES act
// as ENTRIES). Reset empties the table and sets capacity to 16; no clearing
// pass is needed since each slot carries its own valid flag.
`default_nettype none
module lfu_lru_tiebreak_cache_table_unit import lfutb_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   cmd,
  input  wire logic [TAG_BITS-1:0]    key_tag,
  input  wire logic [HANDLE_BITS-1:0] handle_in,
  input  wire logic [SIZE_BITS-1:0]   size_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [HANDLE_BITS-1:0]      handle_out,
  output logic [SIZE_BITS-1:0]        size_out,
  output logic                        evicted,
  output logic [HANDLE_BITS-1:0]      evicted_handle,
  output logic [TAG_BITS-1:0]         evicted_key,
  input  wire logic                   cfg_we,
  input  wire logic [CAP_BITS-1:0]    cfg_data
);

  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int FILL_BITS = $clog2(ENTRIES + 1);

  state_t state, state_next;
  logic [IDX_BITS-1:0]    scan_cnt;
  logic [CAP_BITS-1:0]    capacity;
  logic                   req_cmd;
  logic [KEY_BITS-1:0]    req_key;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [SIZE_BITS-1:0]   req_size;

  logic [ENTRIES:0]       ch_hit, ch_free, ch_vic;
  logic [IDX_BITS-1:0]    ch_hit_idx  [ENTRIES+1];
  logic [IDX_BITS-1:0]    ch_free_idx [ENTRIES+1];
  logic [FILL_BITS-1:0]   ch_fill     [ENTRIES+1];
  logic [IDX_BITS-1:0]    ch_vic_idx  [ENTRIES+1];
  logic [COUNT_BITS-1:0]  ch_vic_cnt  [ENTRIES+1];
  logic [IDX_BITS-1:0]    ch_vic_rank [ENTRIES+1];

  logic [KEY_BITS-1:0]    s_key    [ENTRIES];
  logic [HANDLE_BITS-1:0] s_handle [ENTRIES];
  logic [SIZE_BITS-1:0]   s_size   [ENTRIES];
  logic [IDX_BITS-1:0]    s_rank   [ENTRIES];

  logic [63:0]            key_wide;
  logic [63:0]            vic_key_wide;
  logic [FILL_BITS-1:0]   cap_eff;
  logic                   res_hit, do_evict, upd_en;
  logic [IDX_BITS-1:0]    hit_idx, vic_idx, tgt_idx, slot;
  upd_op_t                upd_op;

  assign key_wide = 64'(key_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd    <= cmd;
      req_key    <= key_wide[KEY_BITS-1:0];
      req_handle <= handle_in;
      req_size   <= size_in;
    end
    if (state == ST_SCAN) scan_cnt <= scan_cnt + 1'b1;
    else                  scan_cnt <= '0;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt == IDX_BITS'(ENTRIES - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (upd_en) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // empty wave enters slot zero
  assign ch_hit[0]      = 1'b0;
  assign ch_free[0]     = 1'b0;
  assign ch_vic[0]      = 1'b0;
  assign ch_hit_idx[0]  = '0;
  assign ch_free_idx[0] = '0;
  assign ch_fill[0]     = '0;
  assign ch_vic_idx[0]  = '0;
  assign ch_vic_cnt[0]  = '0;
  assign ch_vic_rank[0] = '0;

  assign res_hit = ch_hit[ENTRIES];
  assign hit_idx = ch_hit_idx[ENTRIES];
  assign vic_idx = ch_vic_idx[ENTRIES];

  always_comb begin
    if (capacity == '0)                   cap_eff = FILL_BITS'(1);
    else if (int'(capacity) > ENTRIES)    cap_eff = FILL_BITS'(ENTRIES);
    else                                  cap_eff = FILL_BITS'(capacity);
  end

  assign do_evict = (req_cmd == CMD_INSERT) && !res_hit && ch_vic[ENTRIES] &&
                    (ch_fill[ENTRIES] >= cap_eff);
  // lowest free slot once the victim is gone
  assign slot = (do_evict && (!ch_free[ENTRIES] || (vic_idx < ch_free_idx[ENTRIES])))
                ? vic_idx : ch_free_idx[ENTRIES];
  assign tgt_idx = res_hit ? hit_idx : slot;
  assign upd_en  = (state == ST_APPLY) && !(out_valid && !out_ready);

  always_comb begin
    if (res_hit)                      upd_op = OP_TOUCH;
    else if (req_cmd == CMD_INSERT)   upd_op = OP_INSERT;
    else                              upd_op = OP_NONE;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    lfutb_cell #(
      .ID(g), .IDX_BITS(IDX_BITS), .FILL_BITS(FILL_BITS),
      .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_slot (
      .clk        (clk),
      .rst        (rst),
      .req_key    (req_key),
      .hit_i      (ch_hit[g]),
      .hit_idx_i  (ch_hit_idx[g]),
      .free_i     (ch_free[g]),
      .free_idx_i (ch_free_idx[g]),
      .fill_i     (ch_fill[g]),
      .vic_i      (ch_vic[g]),
      .vic_idx_i  (ch_vic_idx[g]),
      .vic_cnt_i  (ch_vic_cnt[g]),
      .vic_rank_i (ch_vic_rank[g]),
      .hit_o      (ch_hit[g+1]),
      .hit_idx_o  (ch_hit_idx[g+1]),
      .free_o     (ch_free[g+1]),
      .free_idx_o (ch_free_idx[g+1]),
      .fill_o     (ch_fill[g+1]),
      .vic_o      (ch_vic[g+1]),
      .vic_idx_o  (ch_vic_idx[g+1]),
      .vic_cnt_o  (ch_vic_cnt[g+1]),
      .vic_rank_o (ch_vic_rank[g+1]),
      .upd_en     (upd_en),
      .upd_op     (upd_op),
      .tgt_idx    (tgt_idx),
      .tgt_rank   (s_rank[hit_idx]),
      .wr_data    (req_cmd == CMD_INSERT),
      .do_evict   (do_evict),
      .evict_idx  (vic_idx),
      .evict_rank (ch_vic_rank[ENTRIES]),
      .wr_handle  (req_handle),
      .wr_size    (req_size),
      .key        (s_key[g]),
      .handle     (s_handle[g]),
      .size       (s_size[g]),
      .rank       (s_rank[g])
    );
  end

  assign vic_key_wide = 64'(s_key[vic_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      evicted        <= do_evict;
      evicted_handle <= do_evict ? s_handle[vic_idx] : '0;
      evicted_key    <= do_evict ? vic_key_wide[TAG_BITS-1:0] : '0;
      if (req_cmd == CMD_LOOKUP) begin
        status     <= res_hit ? STAT_HIT : STAT_MISS;
        handle_out <= res_hit ? s_handle[hit_idx] : '0;
        size_out   <= res_hit ? s_size[hit_idx] : '0;
      end else begin
        status     <= res_hit ? STAT_REFRESH : STAT_NEW;
        handle_out <= req_handle;
        size_out   <= req_size;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lfutb_checker.sv]
// port-level checks for the handle table, bound to the top level
`default_nettype none
module lfutb_checker import lfutb_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             status,
  input wire logic [HANDLE_BITS-1:0] handle_out,
  input wire logic [SIZE_BITS-1:0]   size_out,
  input wire logic                   evicted
);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request was accepted");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_MISS) |-> (handle_out == '0) && (size_out == '0) && !evicted)
    else $error("lookup miss carries data");

  a_evict_on_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> status == STAT_NEW)
    else $error("eviction reported on a request that was not a new insert");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lfu_lru_tiebreak_cache_table_unit lfutb_checker u_lfutb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .handle_out (handle_out),
  .size_out   (size_out),
  .evicted    (evicted)
);
`default_nettype wire

[tb/tb_lfu_lru_tiebreak_cache_table_unit.sv]
// testbench for the lfu/lru handle table: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module tb_lfu_lru_tiebreak_cache_table_unit;
  import lfutb_pkg::*;

  localparam int NSLOT = 16;
  localparam int CNT_MAX = 65535;
  localparam int LAT = NSLOT + 4;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
    logic                   evicted;
    logic [HANDLE_BITS-1:0] ev_handle;
    logic [TAG_BITS-1:0]    ev_key;
  } table_resp_t;

  typedef struct packed {
    logic                   cmd;
    logic [TAG_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
    logic                   has_fixed;
    table_resp_t            fixed;
  } directed_row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, cmd = 0, out_ready = 0, cfg_we = 0;
  logic [TAG_BITS-1:0] key_tag = '0;
  logic [HANDLE_BITS-1:0] handle_in = '0;
  logic [SIZE_BITS-1:0] size_in = '0;
  logic [CAP_BITS-1:0] cfg_data = '0;
  logic in_ready, out_valid, evicted;
  logic [1:0] status;
  logic [HANDLE_BITS-1:0] handle_out, evicted_handle;
  logic [SIZE_BITS-1:0] size_out;
  logic [TAG_BITS-1:0] evicted_key;

  always #5 clk = ~clk;

  lfu_lru_tiebreak_cache_table_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .key_tag(key_tag), .handle_in(handle_in), .size_in(size_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .handle_out(handle_out), .size_out(size_out), .evicted(evicted),
    .evicted_handle(evicted_handle), .evicted_key(evicted_key),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [4:0]             cap_reg;
  logic                   s_valid [NSLOT];
  logic [TAG_BITS-1:0]    s_key [NSLOT];
  logic [HANDLE_BITS-1:0] s_handle [NSLOT];
  logic [SIZE_BITS-1:0]   s_size [NSLOT];
  int unsigned            s_count [NSLOT];
  int unsigned            s_rank [NSLOT];

  table_resp_t expected_q[$];
  int errors = 0, n_got = 0, n_evict = 0, n_sent = 0;
  int send_idle = 35, recv_idle = 64;
  bit hold_recv = 0;
  int cycle = 0;

  function automatic void make_recent(int s, bit was_valid);
    for (int i = 0; i < NSLOT; i++)
      if (i != s && s_valid[i] && (!was_valid || s_rank[i] < s_rank[s])) s_rank[i]++;
    s_rank[s] = 0;
  endfunction

  function automatic void touch_slot(int s);
    if (s_count[s] < CNT_MAX) s_count[s]++;
    make_recent(s, 1);
  endfunction

  function automatic table_resp_t predict_table(logic c, logic [TAG_BITS-1:0] k,
                                                logic [HANDLE_BITS-1:0] h,
                                                logic [SIZE_BITS-1:0] sz);
    table_resp_t r;
    int hit, fill, lim, victim, slot;
    r = '0;
    hit = -1;
    fill = 0;
    victim = -1;
    slot = 0;
    for (int i = NSLOT - 1; i >= 0; i--) if (s_valid[i] && s_key[i] == k) hit = i;
    if (c == CMD_LOOKUP) begin
      if (hit < 0) begin
        r.status = STAT_MISS;
        return r;
      end
      touch_slot(hit);
      r.status = STAT_HIT;
      r.handle = s_handle[hit];
      r.size = s_size[hit];
      return r;
    end
    if (hit >= 0) begin
      s_handle[hit] = h;
      s_size[hit] = sz;
      touch_slot(hit);
      r.status = STAT_REFRESH;
      r.handle = h;
      r.size = sz;
      return r;
    end
    lim = (cap_reg == 0) ? 1 : (cap_reg > NSLOT ? NSLOT : cap_reg);
    for (int i = 0; i < NSLOT; i++) if (s_valid[i]) fill++;
    if (fill >= lim) begin
      for (int i = 0; i < NSLOT; i++)
        if (s_valid[i] && (victim < 0 || s_count[i] < s_count[victim] ||
            (s_count[i] == s_count[victim] && s_rank[i] > s_rank[victim])))
          victim = i;
      if (victim >= 0) begin
        for (int i = 0; i < NSLOT; i++)
          if (s_valid[i] && s_rank[i] > s_rank[victim]) s_rank[i]--;
        s_valid[victim] = 0;
        r.evicted = 1;
        r.ev_handle = s_handle[victim];
        r.ev_key = s_key[victim];
      end
    end
    for (int i = NSLOT - 1; i >= 0; i--) if (!s_valid[i]) slot = i;
    s_key[slot] = k;
    s_handle[slot] = h;
    s_size[slot] = sz;
    s_count[slot] = 1;
    make_recent(slot, 0);
    s_valid[slot] = 1;
    r.status = STAT_NEW;
    r.handle = h;
    r.size = sz;
    return r;
  endfunction

  // valid drops only on an idle cycle or when the caller stops sending
  task automatic send_request(logic c, logic [TAG_BITS-1:0] k,
                              logic [HANDLE_BITS-1:0] h, logic [SIZE_BITS-1:0] sz,
                              bit has_fixed, table_resp_t fixed);
    table_resp_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    cmd <= c;
    key_tag <= k;
    handle_in <= h;
    size_in <= sz;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_table(c, k, h, sz);
    expected_q.push_back(has_fixed ? fixed : p);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_config(logic [4:0] v);
    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    cfg_data <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    cap_reg = v;
  endtask

  // keys drawn mostly from a small pool so hits, refreshes and evictions happen
  function automatic logic [TAG_BITS-1:0] pick_key(int pool);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) return {$urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(pool - 1);
    return 32'h1000 + $urandom_range(pool - 1);
  endfunction

  task automatic random_phase(int n, int pool);
    logic c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(99) < 45) ? CMD_INSERT : CMD_LOOKUP;
      send_request(c, pick_key(pool), HANDLE_BITS'($urandom),
                   SIZE_BITS'({$urandom, $urandom}), 0, '0);
    end
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_recv) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    table_resp_t act, exp_r;
    cycle <= cycle + 1;
    if (!rst && out_valid && out_ready) begin
      act = '{status, handle_out, size_out, evicted, evicted_handle, evicted_key};
      n_got++;
      if (evicted) n_evict++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", act);
      end else begin
        exp_r = expected_q.pop_front();
        if (act !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, act);
        end
      end
    end
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    table_resp_t z;
    z = '0;
    cap_reg = CAP_RESET;
    foreach (s_valid[i]) s_valid[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty table misses, field extremes, refresh, lru tie-break
    rows.push_back('{CMD_LOOKUP, 32'h0, '0, '0, 1, '{STAT_MISS, 0, 0, 0, 0, 0}});
    rows.push_back('{CMD_INSERT, 32'h0, '0, '0, 1, '{STAT_NEW, 0, 0, 0, 0, 0}});
    rows.push_back('{CMD_INSERT, 32'hFFFF_FFFF, '1, '1, 1, '{STAT_NEW, '1, '1, 0, 0, 0}});
    rows.push_back('{CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, z});
    rows.push_back('{CMD_INSERT, 32'h0, 31'h5555_5555, 48'hAAAA_AAAA_AAAA, 0, z});
    rows.push_back('{CMD_LOOKUP, 32'h1234_5678, '1, '1, 1, '{STAT_MISS, 0, 0, 0, 0, 0}});
    for (int k = 0; k < 15; k++)
      rows.push_back('{CMD_INSERT, 32'h100 + k, 31'h100 + k, 48'h7 * k, 0, z});
    rows.push_back('{CMD_LOOKUP, 32'h0, '0, '0, 0, z});
    foreach (rows[i]) send_request(rows[i].cmd, rows[i].key, rows[i].handle, rows[i].size,
                                   rows[i].has_fixed, rows[i].fixed);

    // capacity extremes and a lowered capacity with a full table
    drain_and_config(5'd0);
    random_phase(30, 4);
    drain_and_config(5'd31);
    random_phase(40, 24);
    drain_and_config(5'd3);
    random_phase(40, 6);
    drain_and_config(5'd1);
    random_phase(20, 3);

    // hot key to push its count high
    drain_and_config(5'd16);
    for (int i = 0; i < 40; i++) send_request(CMD_LOOKUP, 32'h0, '0, '0, 0, '0);

    // long receiver stall so the block backs up
    fork
      begin
        hold_recv = 1;
        repeat (300) @(negedge clk);
        hold_recv = 0;
      end
      random_phase(10, 20);
    join

    random_phase(450, 24);
    drain_and_config(5'd8);
    send_idle = 64;
    recv_idle = 35;
    random_phase(450, 12);
    drain_and_config(5'd16);
    send_idle = 0;
    recv_idle = 0;
    random_phase(450, 20);

    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    $display("sent %0d requests, checked %0d results, %0d with eviction", n_sent, n_got,
             n_evict);
    $display("capacity swept over 0, 1, 3, 8, 16 and 31 with varied handshake gaps");
    if (errors == 0 && expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
